[sv/kale_pkg.sv]
`default_nettype none

package kale_pkg;

   // Default sizes of the key table and of the line
   localparam int KEYS_DEFAULT       = 28;
   localparam int LINE_DEPTH_DEFAULT = 64;

   // Field widths
   localparam int KEY_IDX_W   = 5;
   localparam int CODE_W      = 8;
   localparam int TIME_W      = 32;
   localparam int DELAY_W     = 16;
   localparam int POSITION_W  = 6;
   localparam int LENGTH_W    = 7;
   // Wide enough for any key address (up to 256 keys) and any fill count (up to 4096)
   localparam int KEY_EXT_W   = 9;
   localparam int FILL_EXT_W  = 13;

   // Register reset values
   localparam logic [DELAY_W-1:0] INITIAL_DELAY_RESET   = 16'd500;
   localparam logic [DELAY_W-1:0] REPEAT_INTERVAL_RESET = 16'd30;

   // Special character codes
   localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
   localparam logic [CODE_W-1:0] CODE_NONE      = 8'd0;

   // Register indexes
   typedef enum logic [0:0] {
      REG_INITIAL_DELAY   = 1'b0,
      REG_REPEAT_INTERVAL = 1'b1
   } reg_index_type;

   // Command codes
   typedef enum logic [0:0] {
      CMD_KEY_HELD  = 1'b0,
      CMD_CLEAR_ALL = 1'b1
   } command_type;

   // Kind of edit made to the line
   typedef enum logic [1:0] {
      EDIT_NONE   = 2'd0,
      EDIT_APPEND = 2'd1,
      EDIT_DELETE = 2'd2
   } edit_kind_type;

endpackage

`default_nettype wire

[sv/kale_ram.sv]
`default_nettype none

module kale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 28
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, returns the contents before a same-cycle write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/key_autorepeat_line_editor_core.sv]
`default_nettype none

// Channel  Direction  Handshake            Beat contents
// req      in         req_valid/req_ready  command, key_index, char_code, time_ms
// rsp      out        rsp_valid/rsp_ready  accepted, edit_kind, edit_position,
//                                          line_length, overflow
// csr      in         csr_valid/csr_ready  csr_index, csr_wdata (always ready)
//
// One beat per cycle sustained while rsp_ready stays high; the result beat is registered.
// Stage one issues the key-time memory read; stage two does the elapsed-time
// compare, flag and fill-count update and loads the result register.
// A key-time write from the leaving beat is forwarded to the next beat of the same key.
// Reset clears all key flags and the fill count and loads the default delays.
// A stalled result holds the stage behind it; req_ready drops only when both are full.

module key_autorepeat_line_editor_core #(
   parameter int KEYS       = kale_pkg::KEYS_DEFAULT,
   parameter int LINE_DEPTH = kale_pkg::LINE_DEPTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // request channel
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic                                    req_command,
   input  wire logic [kale_pkg::KEY_IDX_W-1:0]          req_key_index,
   input  wire logic [kale_pkg::CODE_W-1:0]             req_char_code,
   input  wire logic [kale_pkg::TIME_W-1:0]             req_time_ms,
   // result channel
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic                                         rsp_accepted,
   output kale_pkg::edit_kind_type                      rsp_edit_kind,
   output logic [kale_pkg::POSITION_W-1:0]              rsp_edit_position,
   output logic [kale_pkg::LENGTH_W-1:0]                rsp_line_length,
   output logic                                         rsp_overflow,
   // configuration channel
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire kale_pkg::reg_index_type                 csr_index,
   input  wire logic [kale_pkg::DELAY_W-1:0]            csr_wdata
);

   import kale_pkg::*;

   localparam int KEY_AW = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int FILL_W = $clog2(LINE_DEPTH + 1);

   localparam logic [KEY_EXT_W-1:0]  KEYS_EXT  = KEY_EXT_W'(KEYS);
   localparam logic [FILL_W-1:0]     FILL_FULL = FILL_W'(LINE_DEPTH);

   // ---------------------------------------------------------------------------
   // Configuration registers
   logic [DELAY_W-1:0] initial_delay_ff;
   logic [DELAY_W-1:0] repeat_interval_ff;

   assign csr_ready = 1'b1;

   // Take a register write
   always_ff @(posedge clock) begin
      if (reset) begin
         initial_delay_ff   <= INITIAL_DELAY_RESET;
         repeat_interval_ff <= REPEAT_INTERVAL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_INITIAL_DELAY:   initial_delay_ff   <= csr_wdata;
            REG_REPEAT_INTERVAL: repeat_interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Handshake and stage control
   logic s1_valid_ff;
   logic s1_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic s1_fire;
   logic req_fire;

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Request stage: decode the key slot and issue the key-time read
   logic [KEY_EXT_W-1:0] req_key_ext;
   logic [KEY_AW-1:0]    req_key_addr;
   logic                 req_in_range;

   assign req_key_ext  = KEY_EXT_W'(req_key_index);
   assign req_key_addr = req_key_ext[KEY_AW-1:0];
   assign req_in_range = req_key_ext < KEYS_EXT;

   command_type          s1_command_ff;
   logic [KEY_AW-1:0]    s1_key_addr_ff;
   logic                 s1_in_range_ff;
   logic [CODE_W-1:0]    s1_code_ff;
   logic [TIME_W-1:0]    s1_time_ff;
   logic                 fwd_hit_ff;
   logic [TIME_W-1:0]    fwd_time_ff;
   logic                 time_wr_en;
   logic                 fwd_hit_in;

   // Forward the key time being written by the leaving beat
   assign fwd_hit_in = time_wr_en && (s1_key_addr_ff == req_key_addr);

   // Hold the request payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_command_ff  <= command_type'(req_command);
         s1_key_addr_ff <= req_key_addr;
         s1_in_range_ff <= req_in_range;
         s1_code_ff     <= req_char_code;
         s1_time_ff     <= req_time_ms;
         fwd_hit_ff     <= fwd_hit_in;
         fwd_time_ff    <= s1_time_ff;
      end
   end

   logic [TIME_W-1:0] ram_rd_data;

   kale_ram #(
      .WIDTH (TIME_W),
      .DEPTH (KEYS)
   ) u_key_time_ram (
      .clock   (clock),
      .wr_en   (time_wr_en),
      .wr_addr (s1_key_addr_ff),
      .wr_data (s1_time_ff),
      .rd_en   (req_fire),
      .rd_addr (req_key_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------------
   // Decision stage: repeat timing, key flags and line edit
   logic [KEYS-1:0]   pressed_ff;
   logic [KEYS-1:0]   pressed_in;
   logic [KEYS-1:0]   repeating_ff;
   logic [KEYS-1:0]   repeating_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;

   logic [TIME_W-1:0] prior_time;
   logic [TIME_W-1:0] elapsed;
   logic              key_event;
   logic              key_pressed;
   logic              key_repeating;
   logic              take;
   logic              set_pressed;
   logic              set_repeating;
   edit_kind_type     kind;
   logic [FILL_W-1:0] position;
   logic              overflow;

   assign prior_time = fwd_hit_ff ? fwd_time_ff : ram_rd_data;
   assign elapsed    = s1_time_ff - prior_time;
   assign key_event  = (s1_command_ff == CMD_KEY_HELD) && s1_in_range_ff;

   always_comb begin
      key_pressed   = 1'b0;
      key_repeating = 1'b0;
      if (key_event) begin
         key_pressed   = pressed_ff[s1_key_addr_ff];
         key_repeating = repeating_ff[s1_key_addr_ff];
      end
   end

   // Apply the typematic timing
   always_comb begin
      take          = 1'b0;
      set_pressed   = 1'b0;
      set_repeating = 1'b0;
      if (key_event) begin
         if (!key_pressed) begin
            take        = 1'b1;
            set_pressed = 1'b1;
         end else if (!key_repeating) begin
            if (elapsed > TIME_W'(initial_delay_ff)) begin
               take          = 1'b1;
               set_repeating = 1'b1;
            end
         end else if (elapsed > TIME_W'(repeat_interval_ff)) begin
            take = 1'b1;
         end
      end
   end

   assign time_wr_en = s1_fire && take;

   // Edit the line
   always_comb begin
      kind     = EDIT_NONE;
      position = '0;
      overflow = 1'b0;
      fill_in  = fill_ff;
      if (take) begin
         if (s1_code_ff == CODE_BACKSPACE) begin
            if (fill_ff != '0) begin
               kind     = EDIT_DELETE;
               position = fill_ff - FILL_W'(1);
               fill_in  = fill_ff - FILL_W'(1);
            end
         end else if (s1_code_ff == CODE_NONE) begin
            kind = EDIT_NONE;
         end else if (fill_ff < FILL_FULL) begin
            kind     = EDIT_APPEND;
            position = fill_ff;
            fill_in  = fill_ff + FILL_W'(1);
         end else begin
            overflow = 1'b1;
         end
      end
   end

   // Next key flags: drop all on a clear, set the slot's flags on a take
   always_comb begin
      pressed_in   = pressed_ff;
      repeating_in = repeating_ff;
      if (s1_command_ff == CMD_CLEAR_ALL) begin
         pressed_in   = '0;
         repeating_in = '0;
      end else begin
         if (set_pressed) begin
            pressed_in[s1_key_addr_ff] = 1'b1;
         end
         if (set_repeating) begin
            repeating_in[s1_key_addr_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff   <= '0;
         repeating_ff <= '0;
         fill_ff      <= '0;
      end else if (s1_fire) begin
         pressed_ff   <= pressed_in;
         repeating_ff <= repeating_in;
         fill_ff      <= fill_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Result register
   logic [FILL_EXT_W-1:0] position_ext;
   logic [FILL_EXT_W-1:0] fill_ext_in;

   assign position_ext = FILL_EXT_W'(position);
   assign fill_ext_in  = FILL_EXT_W'(fill_in);

   logic                  rsp_accepted_ff;
   edit_kind_type         rsp_edit_kind_ff;
   logic [POSITION_W-1:0] rsp_edit_position_ff;
   logic [LENGTH_W-1:0]   rsp_line_length_ff;
   logic                  rsp_overflow_ff;

   // Load the result beat
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_accepted_ff      <= take;
         rsp_edit_kind_ff     <= kind;
         rsp_edit_position_ff <= position_ext[POSITION_W-1:0];
         rsp_line_length_ff   <= fill_ext_in[LENGTH_W-1:0];
         rsp_overflow_ff      <= overflow;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_edit_kind     = rsp_edit_kind_ff;
   assign rsp_edit_position = rsp_edit_position_ff;
   assign rsp_line_length   = rsp_line_length_ff;
   assign rsp_overflow      = rsp_overflow_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   a_repeating_implies_pressed: assert property (
      @(posedge clock) disable iff (reset)
      (repeating_ff & ~pressed_ff) == '0
   ) else $error("key repeating without being pressed");

   a_clear_drops_flags: assert property (
      @(posedge clock) disable iff (reset)
      (s1_fire && s1_command_ff == CMD_CLEAR_ALL) |=>
         (pressed_ff == '0) && (repeating_ff == '0)
   ) else $error("clear left key flags set");

   a_append_grows_line: assert property (
      @(posedge clock) disable iff (reset)
      (s1_fire && kind == EDIT_APPEND) |=> (fill_ff == $past(fill_ff) + FILL_W'(1))
   ) else $error("append did not grow the line");

   a_edit_needs_accept: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_edit_kind_ff != EDIT_NONE || rsp_overflow_ff)) |->
         rsp_accepted_ff
   ) else $error("edit or overflow reported on a rejected beat");

   a_overflow_only_full: assert property (
      @(posedge clock) disable iff (reset)
      (s1_fire && overflow) |-> (fill_ff == FILL_FULL)
   ) else $error("overflow flagged on a line that is not full");

endmodule

`default_nettype wire

[tb/tb_key_autorepeat_line_editor_core.sv]
`default_nettype none

module tb_key_autorepeat_line_editor_core;
   timeunit 1ns;
   timeprecision 1ps;

   import kale_pkg::*;

   localparam int KEYS       = KEYS_DEFAULT;
   localparam int LINE_DEPTH = LINE_DEPTH_DEFAULT;

   typedef struct {
      command_type               command;
      logic [KEY_IDX_W-1:0]      key_index;
      logic [CODE_W-1:0]         char_code;
      logic [TIME_W-1:0]         time_ms;
   } key_event_type;

   typedef struct {
      logic                      accepted;
      edit_kind_type             kind;
      logic [POSITION_W-1:0]     position;
      logic [LENGTH_W-1:0]       length;
      logic                      overflow;
   } line_edit_type;

   // Block ports
   logic                    clock;
   logic                    reset             = 1'b1;
   logic                    req_valid         = 1'b0;
   logic                    req_ready;
   logic                    req_command       = CMD_KEY_HELD;
   logic [KEY_IDX_W-1:0]    req_key_index     = '0;
   logic [CODE_W-1:0]       req_char_code     = '0;
   logic [TIME_W-1:0]       req_time_ms       = '0;
   logic                    rsp_valid;
   logic                    rsp_ready         = 1'b0;
   logic                    rsp_accepted;
   edit_kind_type           rsp_edit_kind;
   logic [POSITION_W-1:0]   rsp_edit_position;
   logic [LENGTH_W-1:0]     rsp_line_length;
   logic                    rsp_overflow;
   logic                    csr_valid         = 1'b0;
   logic                    csr_ready;
   reg_index_type           csr_index         = REG_INITIAL_DELAY;
   logic [DELAY_W-1:0]      csr_wdata         = '0;

   // Key events waiting to go out, and line edits still due back
   key_event_type           pending_events[$];
   line_edit_type           due_edits[$];
   key_event_type           held_event;
   line_edit_type           due_edit;

   // Idling odds, in percent, set per phase
   int                      sender_idle_pct   = 0;
   int                      recv_stall_pct    = 0;
   int                      error_count       = 0;

   // Shadow of the block's state and delay registers
   logic [DELAY_W-1:0]      delay_first       = INITIAL_DELAY_RESET;
   logic [DELAY_W-1:0]      delay_next        = REPEAT_INTERVAL_RESET;
   bit                      key_pressed[KEYS];
   bit                      key_repeating[KEYS];
   logic [TIME_W-1:0]       key_last_ms[KEYS];
   int                      line_fill         = 0;

   // Running timestamp for the typing sequences
   logic [TIME_W-1:0]       typing_ms         = '0;

   key_autorepeat_line_editor_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_key_index     (req_key_index),
      .req_char_code     (req_char_code),
      .req_time_ms       (req_time_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_edit_kind     (rsp_edit_kind),
      .rsp_edit_position (rsp_edit_position),
      .rsp_line_length   (rsp_line_length),
      .rsp_overflow      (rsp_overflow),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Work out the line edit an event causes and advance the shadow state
   function automatic line_edit_type predict_edit(key_event_type ev);
      line_edit_type  e;
      logic [TIME_W-1:0] elapsed;
      bit             take;
      e.accepted = 1'b0;
      e.kind     = EDIT_NONE;
      e.position = '0;
      e.overflow = 1'b0;
      take       = 1'b0;
      if (ev.command == CMD_CLEAR_ALL) begin
         foreach (key_pressed[k]) begin
            key_pressed[k]   = 1'b0;
            key_repeating[k] = 1'b0;
         end
      end else if (ev.key_index < KEYS) begin
         elapsed = ev.time_ms - key_last_ms[ev.key_index];
         if (!key_pressed[ev.key_index]) begin
            key_pressed[ev.key_index] = 1'b1;
            take = 1'b1;
         end else if (!key_repeating[ev.key_index]) begin
            if (elapsed > delay_first) begin
               key_repeating[ev.key_index] = 1'b1;
               take = 1'b1;
            end
         end else if (elapsed > delay_next) begin
            take = 1'b1;
         end
         if (take) begin
            key_last_ms[ev.key_index] = ev.time_ms;
            e.accepted = 1'b1;
            if (ev.char_code == CODE_BACKSPACE) begin
               if (line_fill > 0) begin
                  line_fill  = line_fill - 1;
                  e.kind     = EDIT_DELETE;
                  e.position = line_fill[POSITION_W-1:0];
               end
            end else if (ev.char_code != CODE_NONE) begin
               if (line_fill < LINE_DEPTH) begin
                  e.kind     = EDIT_APPEND;
                  e.position = line_fill[POSITION_W-1:0];
                  line_fill  = line_fill + 1;
               end else begin
                  e.overflow = 1'b1;
               end
            end
         end
      end
      e.length = line_fill[LENGTH_W-1:0];
      return e;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Driver: hold each beat until taken, predict it on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            due_edits.push_back(predict_edit(held_event));
         if (!req_valid || req_ready) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               held_event     = pending_events.pop_front();
               req_valid     <= 1'b1;
               req_command   <= held_event.command;
               req_key_index <= held_event.key_index;
               req_char_code <= held_event.char_code;
               req_time_ms   <= held_event.time_ms;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result beat with the oldest due edit
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_edits.size() == 0) begin
               $error("result beat with no edit due");
               error_count++;
            end else begin
               due_edit = due_edits.pop_front();
               check_field("accepted", due_edit.accepted, rsp_accepted);
               check_field("edit_kind", due_edit.kind, rsp_edit_kind);
               check_field("edit_position", due_edit.position, rsp_edit_position);
               check_field("line_length", due_edit.length, rsp_line_length);
               check_field("overflow", due_edit.overflow, rsp_overflow);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic push_event(command_type cmd, logic [KEY_IDX_W-1:0] key,
                             logic [CODE_W-1:0] code, logic [TIME_W-1:0] stamp);
      key_event_type ev;
      ev.command   = cmd;
      ev.key_index = key;
      ev.char_code = code;
      ev.time_ms   = stamp;
      pending_events.push_back(ev);
   endtask

   // Drain everything in flight, then let the pipeline settle
   task automatic wait_idle();
      while (pending_events.size() != 0 || req_valid || due_edits.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [DELAY_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_INITIAL_DELAY:   delay_first = value;
         REG_REPEAT_INTERVAL: delay_next  = value;
         default: ;
      endcase
   endtask

   task automatic set_delays(logic [DELAY_W-1:0] first, logic [DELAY_W-1:0] next);
      write_csr(REG_INITIAL_DELAY, first);
      write_csr(REG_REPEAT_INTERVAL, next);
   endtask

   // Held-key sequences with steps near the delay thresholds, plus some noise
   task automatic type_keys(int count, int backspace_pct);
      int                    made;
      int                    roll;
      int                    len;
      logic [KEY_IDX_W-1:0]  key;
      logic [CODE_W-1:0]     code;
      logic [TIME_W-1:0]     step;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            push_event(CMD_CLEAR_ALL, KEY_IDX_W'($urandom), CODE_W'($urandom), $urandom);
            made++;
         end else if (roll < 6) begin
            // out-of-range slot, ignored by the block
            push_event(CMD_KEY_HELD, KEY_IDX_W'($urandom_range(KEYS, 31)),
                       CODE_W'($urandom), $urandom);
         end else if (roll < 10) begin
            push_event(CMD_KEY_HELD, KEY_IDX_W'($urandom_range(KEYS - 1)),
                       CODE_W'($urandom), $urandom);
            made++;
         end else begin
            // release all keys now and then so first presses recur
            if ($urandom_range(99) < 30) begin
               push_event(CMD_CLEAR_ALL, '0, '0, typing_ms);
               made++;
            end
            key  = KEY_IDX_W'($urandom_range(KEYS - 1));
            roll = $urandom_range(99);
            if (roll < backspace_pct)
               code = CODE_BACKSPACE;
            else if (roll < backspace_pct + 5)
               code = CODE_NONE;
            else
               code = CODE_W'($urandom_range(1, 255));
            len = $urandom_range(2, 8);
            repeat (len) begin
               case ($urandom_range(9))
                  0: step = '0;
                  1: step = TIME_W'($urandom_range(1, 3));
                  2: step = TIME_W'(delay_first) - 1;
                  3: step = TIME_W'(delay_first);
                  4: step = TIME_W'(delay_first) + 1;
                  5: step = TIME_W'(delay_next) - 1;
                  6: step = TIME_W'(delay_next);
                  7: step = TIME_W'(delay_next) + 1;
                  8: step = TIME_W'($urandom_range(0, 2 * int'(delay_next) + 2));
                  default: step = $urandom;
               endcase
               typing_ms = typing_ms + step;
               push_event(CMD_KEY_HELD, key, code, typing_ms);
               made++;
            end
         end
      end
   endtask

   // Stimulus and phase sequencing
   initial begin
      foreach (key_pressed[k]) begin
         key_pressed[k]   = 1'b0;
         key_repeating[k] = 1'b0;
         key_last_ms[k]   = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed checks at the reset delays
      push_event(CMD_KEY_HELD, 5'd1,  CODE_BACKSPACE, 32'd5);   // backspace on empty line
      push_event(CMD_KEY_HELD, 5'd2,  CODE_NONE,      32'd7);   // accepted code zero
      push_event(CMD_KEY_HELD, 5'd0,  8'h61, 32'd1000);         // first press
      push_event(CMD_KEY_HELD, 5'd0,  8'h61, 32'd1100);         // too soon
      push_event(CMD_KEY_HELD, 5'd0,  8'h61, 32'd1500);         // exactly the delay
      push_event(CMD_KEY_HELD, 5'd0,  8'h61, 32'd1501);         // first repeat
      push_event(CMD_KEY_HELD, 5'd0,  8'h61, 32'd1531);         // exactly the interval
      push_event(CMD_KEY_HELD, 5'd0,  8'h61, 32'd1532);         // later repeat
      push_event(CMD_KEY_HELD, 5'd0,  CODE_BACKSPACE, 32'd1563);
      push_event(CMD_KEY_HELD, 5'd28, 8'h41, 32'd2000);         // slot out of range
      push_event(CMD_KEY_HELD, 5'd31, 8'hFF, 32'hFFFF_FFFF);
      push_event(CMD_CLEAR_ALL, 5'd31, 8'hFF, 32'hFFFF_FFFF);
      push_event(CMD_KEY_HELD, 5'd0,  8'h62, 32'd1563);         // first press after clear
      push_event(CMD_KEY_HELD, 5'd3,  8'hFF, 32'hFFFF_FF00);
      push_event(CMD_KEY_HELD, 5'd3,  8'hFF, 32'h0000_0100);    // elapsed across the wrap
      push_event(CMD_KEY_HELD, 5'd3,  8'hFF, 32'h0000_011F);
      push_event(CMD_KEY_HELD, 5'd27, 8'h80, 32'd0);
      push_event(CMD_KEY_HELD, 5'd27, CODE_BACKSPACE, 32'h0000_01F5);
      push_event(CMD_CLEAR_ALL, '0, '0, '0);
      typing_ms = 32'd10_000;
      type_keys(60, 30);
      wait_idle();

      // Zero delays, appends only: fill the line past full
      sender_idle_pct = 83;
      recv_stall_pct  = 0;
      set_delays('0, '0);
      type_keys(100, 0);
      wait_idle();

      // Largest delays, heavy deleting
      sender_idle_pct = 0;
      recv_stall_pct  = 83;
      set_delays('1, '1);
      type_keys(70, 60);
      wait_idle();

      // Random delays, both sides idling lightly
      sender_idle_pct = 13;
      recv_stall_pct  = 13;
      set_delays(DELAY_W'($urandom_range(0, 1000)), DELAY_W'($urandom_range(0, 200)));
      type_keys(70, 45);
      wait_idle();

      // Short first delay, long repeat interval
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      set_delays(16'd1, 16'hFFFF);
      type_keys(70, 20);
      wait_idle();

      // Back to the reset delays with the timestamp about to wrap
      sender_idle_pct = 0;
      recv_stall_pct  = 83;
      set_delays(INITIAL_DELAY_RESET, REPEAT_INTERVAL_RESET);
      typing_ms = 32'hFFFF_F000;
      type_keys(70, 30);
      wait_idle();

      if (error_count == 0)
         $display("tb_key_autorepeat_line_editor_core passed");
      else
         $display("tb_key_autorepeat_line_editor_core failed");
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #5_000_000;
      $display("tb_key_autorepeat_line_editor_core failed");
      $finish;
   end

endmodule

`default_nettype wire
